// ===== src/mbsd_pkg.sv =====
// Shared types and constants for the block-sum downsampler.
// Used by every module of the block and by its checker.
package mbsd_pkg;

  localparam int SIZE_W          = 7;
  localparam int POS_W           = 6;
  localparam int SUM_W           = 44;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 7;
  localparam int OUT_DATA_W      = SUM_W + 2 * POS_W;
  localparam int OUTQ_DEPTH      = 3;
  localparam int MAX_SIZE_DEF    = 64;
  localparam int WEIGHT_BITS_DEF = 32;

  localparam logic [SIZE_W-1:0] RESET_SOURCE = 7'd64;
  localparam logic [SIZE_W-1:0] RESET_TARGET = 7'd8;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET = 2'd1;

  // configuration unit status
  typedef struct packed {
    logic              ok;
    logic              busy;
    logic              clear;
    logic [SIZE_W-1:0] scale;
    logic [SIZE_W-1:0] src;
  } cfg_stat_t;

  // position of the item at the input
  typedef struct packed {
    logic              first;
    logic              block_end;
    logic              last;
    logic [SIZE_W-1:0] dst_col;
    logic [SIZE_W-1:0] dst_row;
  } pos_t;

  // one result item
  typedef struct packed {
    logic             err;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [SUM_W-1:0] sum;
  } res_t;

endpackage

// ===== src/mbsd_cfg.sv =====
// Size registers and a bit-serial divider that derives block scale and validity.
// Depends on mbsd_pkg.
module mbsd_cfg #(
  parameter int MAX_SIZE = mbsd_pkg::MAX_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [mbsd_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [mbsd_pkg::CFG_DATA_W-1:0]    wr_data,
  output mbsd_pkg::cfg_stat_t                stat
);

  localparam int W      = mbsd_pkg::SIZE_W;
  localparam int STEP_W = $clog2(W);
  localparam logic [W-1:0] RESET_SCALE = W'(mbsd_pkg::RESET_SOURCE / mbsd_pkg::RESET_TARGET);
  localparam logic RESET_OK =
      (int'(mbsd_pkg::RESET_SOURCE) <= MAX_SIZE) && (int'(mbsd_pkg::RESET_TARGET) <= MAX_SIZE) &&
      (mbsd_pkg::RESET_TARGET != '0) && (mbsd_pkg::RESET_SOURCE != '0) &&
      ((mbsd_pkg::RESET_SOURCE % mbsd_pkg::RESET_TARGET) == '0);

  logic [W-1:0]      source_size;
  logic [W-1:0]      target_size;
  logic              busy;
  logic [STEP_W-1:0] step;
  logic [W-1:0]      rem;
  logic [W-1:0]      quo;
  logic [W-1:0]      scale;
  logic              ok;
  logic              known;

  logic [W:0]   trial;
  logic         fits;
  logic [W-1:0] rem_next;
  logic [W-1:0] quo_next;
  logic         ok_next;

  assign known = wr_en && (wr_index == mbsd_pkg::REG_SOURCE || wr_index == mbsd_pkg::REG_TARGET);

  // one quotient bit per cycle, MSB first
  always_comb begin
    trial    = {rem, source_size[step]};
    fits     = trial >= {1'b0, target_size};
    rem_next = fits ? W'(trial - {1'b0, target_size}) : W'(trial);
    quo_next = {quo[W-2:0], fits};
    ok_next  = (source_size != '0) && (target_size != '0) &&
               (32'(source_size) <= 32'(MAX_SIZE)) && (32'(target_size) <= 32'(MAX_SIZE)) &&
               (rem_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_size <= mbsd_pkg::RESET_SOURCE;
      target_size <= mbsd_pkg::RESET_TARGET;
      busy        <= 1'b0;
      step        <= '0;
      rem         <= '0;
      quo         <= '0;
      scale       <= RESET_SCALE;
      ok          <= RESET_OK;
    end else if (known) begin
      if (wr_index == mbsd_pkg::REG_SOURCE) begin
        source_size <= wr_data;
      end else begin
        target_size <= wr_data;
      end
      busy <= 1'b1;
      step <= STEP_W'(W - 1);
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
      if (step == '0) begin
        busy  <= 1'b0;
        scale <= quo_next;
        ok    <= ok_next;
      end else begin
        step <= step - 1'b1;
      end
    end
  end

  assign stat.ok    = ok;
  assign stat.busy  = busy;
  assign stat.clear = known;
  assign stat.scale = scale;
  assign stat.src   = source_size;

endmodule

// ===== src/mbsd_pos.sv =====
// Source, sub-block and destination position counters.
// Depends on mbsd_pkg.
module mbsd_pos (
  input  logic                clk,
  input  logic                rst,
  input  mbsd_pkg::cfg_stat_t stat,
  input  logic                advance,
  output mbsd_pkg::pos_t      pos
);

  localparam int W = mbsd_pkg::SIZE_W;

  logic [W-1:0] src_col, src_row, sub_col, sub_row, dst_col, dst_row;
  logic [W-1:0] src_col_next, src_row_next, sub_col_next, sub_row_next;
  logic [W-1:0] dst_col_next, dst_row_next;
  logic         sub_col_end, sub_row_end, src_col_end, src_row_end;

  always_comb begin
    sub_col_end = sub_col == stat.scale - 1'b1;
    sub_row_end = sub_row == stat.scale - 1'b1;
    src_col_end = src_col == stat.src - 1'b1;
    src_row_end = src_row == stat.src - 1'b1;

    src_col_next = src_col + 1'b1;
    src_row_next = src_row;
    sub_col_next = sub_col_end ? '0 : sub_col + 1'b1;
    sub_row_next = sub_row;
    dst_col_next = sub_col_end ? dst_col + 1'b1 : dst_col;
    dst_row_next = dst_row;
    if (src_col_end) begin
      src_col_next = '0;
      sub_col_next = '0;
      dst_col_next = '0;
      src_row_next = src_row + 1'b1;
      sub_row_next = sub_row_end ? '0 : sub_row + 1'b1;
      dst_row_next = sub_row_end ? dst_row + 1'b1 : dst_row;
      // wrap to the first cell of the next matrix
      if (src_row_end) begin
        src_row_next = '0;
        sub_row_next = '0;
        dst_row_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || stat.clear) begin
      src_col <= '0;
      src_row <= '0;
      sub_col <= '0;
      sub_row <= '0;
      dst_col <= '0;
      dst_row <= '0;
    end else if (advance) begin
      src_col <= src_col_next;
      src_row <= src_row_next;
      sub_col <= sub_col_next;
      sub_row <= sub_row_next;
      dst_col <= dst_col_next;
      dst_row <= dst_row_next;
    end
  end

  assign pos.first     = (sub_col == '0) && (sub_row == '0);
  assign pos.block_end = sub_col_end && sub_row_end;
  assign pos.last      = src_col_end && src_row_end;
  assign pos.dst_col   = dst_col;
  assign pos.dst_row   = dst_row;

endmodule

// ===== src/mbsd_acc.sv =====
// Column accumulator memory with read-modify-write stage and write forwarding.
// Depends on mbsd_pkg.
module mbsd_acc #(
  parameter int MAX_SIZE    = mbsd_pkg::MAX_SIZE_DEF,
  parameter int WEIGHT_BITS = mbsd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic                   ok,
  input  mbsd_pkg::pos_t         pos,
  input  logic [WEIGHT_BITS-1:0] weight,
  output logic                   busy,
  output logic                   push,
  output mbsd_pkg::res_t         res
);

  localparam int IDX_W = $clog2(MAX_SIZE);
  localparam int SW    = mbsd_pkg::SUM_W;
  localparam int PW    = mbsd_pkg::POS_W;

  logic [SW-1:0]    mem [MAX_SIZE];
  logic [SW-1:0]    rdata;
  logic [IDX_W-1:0] ridx;

  logic             s1_valid;
  logic             s1_err;
  logic             s1_first;
  logic             s1_end;
  logic             s1_last;
  logic [IDX_W-1:0] s1_idx;
  logic [PW-1:0]    s1_col;
  logic [PW-1:0]    s1_row;
  logic [SW-1:0]    s1_w;

  logic             fwd_valid;
  logic [IDX_W-1:0] fwd_idx;
  logic [SW-1:0]    fwd_data;

  logic [SW-1:0]    operand;
  logic [SW-1:0]    sum;
  logic             wr_en;

  assign ridx = IDX_W'(pos.dst_col);

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= mem[ridx];
    end
    if (wr_en) begin
      mem[s1_idx] <= sum;
    end
  end

  // the write of the previous item lands on the edge that reads for this one
  always_comb begin
    operand = (fwd_valid && fwd_idx == s1_idx) ? fwd_data : rdata;
    sum     = s1_first ? s1_w : operand + s1_w;
    wr_en   = s1_valid && !s1_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (wr_en) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err   <= !ok;
      s1_first <= pos.first;
      s1_end   <= pos.block_end;
      s1_last  <= pos.last;
      s1_idx   <= ridx;
      s1_col   <= PW'(pos.dst_col);
      s1_row   <= PW'(pos.dst_row);
      s1_w     <= SW'(weight);
    end
    if (wr_en) begin
      fwd_idx  <= s1_idx;
      fwd_data <= sum;
    end
  end

  assign busy     = s1_valid;
  assign push     = s1_valid && (s1_err || s1_end);
  assign res.err  = s1_err;
  assign res.last = s1_err ? 1'b0 : s1_last;
  assign res.row  = s1_err ? '0 : s1_row;
  assign res.col  = s1_err ? '0 : s1_col;
  assign res.sum  = s1_err ? '0 : sum;

endmodule

// ===== src/mbsd_outq.sv =====
// Small result queue that parts the accumulator stage from the output side.
// Depends on mbsd_pkg.
module mbsd_outq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mbsd_pkg::res_t          push_res,
  input  logic                    pop,
  output logic                    head_valid,
  output mbsd_pkg::res_t          head_res,
  output logic [1:0]              count
);

  localparam int DEPTH = mbsd_pkg::OUTQ_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  mbsd_pkg::res_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head_valid = count != '0;
  assign head_res   = slots[rd_ptr];

endmodule

// ===== src/matrix_block_sum_downsampler_unit.sv =====
// Block-sum downsampler: sums scale-by-scale blocks of a streamed square matrix.
// The item that completes a block passes the stage-1 register, then the result queue.
// Throughput: one item per cycle while the result queue has room and the divider
// is idle, set by the read-modify-write of the accumulator memory; a known register
// write holds the input while the divider derives the scale. Reset clears counters,
// queue and sizes to 64 and 8; accumulator memory is not cleared.
module matrix_block_sum_downsampler_unit #(
  parameter int MAX_SIZE    = mbsd_pkg::MAX_SIZE_DEF,
  parameter int WEIGHT_BITS = mbsd_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((WEIGHT_BITS + 7) / 8) * 8-1:0] s_tdata,  // weight
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [mbsd_pkg::OUT_DATA_W-1:0]       m_tdata,  // block_sum, out_col, out_row
  output logic                                  m_tlast,  // final_cell
  output logic                                  m_tuser,  // size_error
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mbsd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mbsd_pkg::CFG_DATA_W-1:0]       cfg_data
);

  mbsd_pkg::cfg_stat_t stat;
  mbsd_pkg::pos_t      pos;
  mbsd_pkg::res_t      acc_res;
  mbsd_pkg::res_t      head_res;
  logic                accept;
  logic                s1_busy;
  logic                push;
  logic                pop;
  logic [1:0]          count;
  logic [2:0]          pending;

  assign cfg_ready = 1'b1;

  // a held stage-1 item may still add a result; leave room for it
  assign pending  = {1'b0, count} + {2'b0, s1_busy};
  assign s_tready = !stat.busy && (pending < 3'(mbsd_pkg::OUTQ_DEPTH));
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  mbsd_cfg #(.MAX_SIZE(MAX_SIZE)) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .stat     (stat)
  );

  mbsd_pos u_pos (
    .clk     (clk),
    .rst     (rst),
    .stat    (stat),
    .advance (accept && stat.ok),
    .pos     (pos)
  );

  mbsd_acc #(.MAX_SIZE(MAX_SIZE), .WEIGHT_BITS(WEIGHT_BITS)) u_acc (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .ok     (stat.ok),
    .pos    (pos),
    .weight (s_tdata[WEIGHT_BITS-1:0]),
    .busy   (s1_busy),
    .push   (push),
    .res    (acc_res)
  );

  mbsd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_res   (acc_res),
    .pop        (pop),
    .head_valid (m_tvalid),
    .head_res   (head_res),
    .count      (count)
  );

  assign m_tdata = {head_res.row, head_res.col, head_res.sum};
  assign m_tlast = head_res.last;
  assign m_tuser = head_res.err;

endmodule

// ===== src/mbsd_checker.sv =====
// Port-level checks for the block-sum downsampler, bound to the top level.
// Depends on mbsd_pkg.
module mbsd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [mbsd_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic                               m_tlast,
  input logic                               m_tuser,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [mbsd_pkg::CFG_INDEX_W-1:0]   cfg_index
);

  // an error item carries no sum, no coordinates and no final mark
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == '0) && !m_tlast)
    else $error("error item with nonzero payload");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a size write holds off input while the scale is recomputed
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready &&
    (cfg_index == mbsd_pkg::REG_SOURCE || cfg_index == mbsd_pkg::REG_TARGET)
    |=> !s_tready)
    else $error("input ready during scale update");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
    $stable(m_tuser))
    else $error("stalled output item changed");

endmodule

bind matrix_block_sum_downsampler_unit mbsd_checker u_mbsd_checker (.*);

// ===== verif/matrix_block_sum_downsampler_unit_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the block-sum downsampler: watches the config, input and result
// channels, predicts every block sum and compares it with the result items.
// Depends on mbsd_pkg for register indexes, widths, reset sizes and the result layout.
module matrix_block_sum_downsampler_unit_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // weight
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [mbsd_pkg::OUT_DATA_W-1:0] m_tdata,   // block_sum, out_col, out_row
  input  logic                            m_tlast,   // final_cell
  input  logic                            m_tuser,   // size_error
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [mbsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbsd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors_seen,
  output int                              sums_pending
);

  localparam int SIZE_LIMIT = mbsd_pkg::MAX_SIZE_DEF;

  typedef logic [mbsd_pkg::SUM_W-1:0] sum_t;

  logic [mbsd_pkg::SIZE_W-1:0] src_size;
  logic [mbsd_pkg::SIZE_W-1:0] tgt_size;
  sum_t                        col_sums [SIZE_LIMIT];
  int unsigned                 src_col, src_row, sub_col, sub_row, dst_col, dst_row;
  mbsd_pkg::res_t              sums_due [$];

  initial begin
    errors_seen  = 0;
    sums_pending = 0;
  end

  function automatic bit sizes_usable();
    if (src_size == '0 || tgt_size == '0) return 1'b0;
    if (int'(src_size) > SIZE_LIMIT || int'(tgt_size) > SIZE_LIMIT) return 1'b0;
    return (src_size % tgt_size) == '0;
  endfunction

  function automatic void restart_matrix();
    src_col = 0;
    src_row = 0;
    sub_col = 0;
    sub_row = 0;
    dst_col = 0;
    dst_row = 0;
  endfunction

  // Sum a cell into its column, queue closed block sums; error item on bad sizes.
  function automatic void accumulate_cell(input logic [31:0] w);
    mbsd_pkg::res_t exp_sum;
    int unsigned    scale;
    int unsigned    slot;
    int unsigned    src;
    exp_sum = '0;
    if (!sizes_usable()) begin
      exp_sum.err = 1'b1;
      sums_due.push_back(exp_sum);
      return;
    end
    src   = 32'(src_size);
    scale = 32'(src_size / tgt_size);
    slot  = dst_col % SIZE_LIMIT;
    if (sub_col == 0 && sub_row == 0) col_sums[slot] = sum_t'(w);
    else col_sums[slot] = col_sums[slot] + sum_t'(w);
    if (sub_col == scale - 1 && sub_row == scale - 1) begin
      exp_sum.sum  = col_sums[slot];
      exp_sum.col  = dst_col[mbsd_pkg::POS_W-1:0];
      exp_sum.row  = dst_row[mbsd_pkg::POS_W-1:0];
      exp_sum.last = (src_col == src - 1) && (src_row == src - 1);
      sums_due.push_back(exp_sum);
    end
    sub_col++;
    if (sub_col >= scale) begin
      sub_col = 0;
      dst_col++;
    end
    src_col++;
    if (src_col >= src) begin
      src_col = 0;
      sub_col = 0;
      dst_col = 0;
      src_row++;
      sub_row++;
      if (sub_row >= scale) begin
        sub_row = 0;
        dst_row++;
      end
      if (src_row >= src) restart_matrix();
    end
  endfunction

  function automatic void compare_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      errors_seen++;
    end
  endfunction

  function automatic void check_result();
    mbsd_pkg::res_t want;
    mbsd_pkg::res_t got;
    got = {m_tuser, m_tlast, m_tdata};
    if (sums_due.size() == 0) begin
      $display("%0t: unexpected item: expected none, actual sum %0h col %0d row %0d last %b err %b",
               $time, got.sum, got.col, got.row, got.last, got.err);
      errors_seen++;
      return;
    end
    want = sums_due.pop_front();
    compare_field("block_sum", 64'(want.sum), 64'(got.sum));
    compare_field("out_col", 64'(want.col), 64'(got.col));
    compare_field("out_row", 64'(want.row), 64'(got.row));
    compare_field("final_cell", 64'(want.last), 64'(got.last));
    compare_field("size_error", 64'(want.err), 64'(got.err));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      src_size = mbsd_pkg::RESET_SOURCE;
      tgt_size = mbsd_pkg::RESET_TARGET;
      restart_matrix();
      sums_due.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      // a write to a known register restarts the matrix; other indexes do nothing
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mbsd_pkg::REG_SOURCE) begin
          src_size = cfg_data;
          restart_matrix();
        end else if (cfg_index == mbsd_pkg::REG_TARGET) begin
          tgt_size = cfg_data;
          restart_matrix();
        end
      end
      if (s_tvalid && s_tready) accumulate_cell(s_tdata);
    end
    sums_pending = sums_due.size();
  end

endmodule

// ===== verif/matrix_block_sum_downsampler_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the block-sum downsampler: makes the config writes, the weight
// stream and the result-side stalls, and gives the verdict.
// Depends on mbsd_pkg, the block and matrix_block_sum_downsampler_unit_checker.
module matrix_block_sum_downsampler_unit_tb;

  localparam int CELL_COUNT    = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  typedef logic [mbsd_pkg::CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [mbsd_pkg::CFG_DATA_W-1:0]  cfg_data_t;

  localparam cfg_index_t REG_SPARE_LO = 2'd2;
  localparam cfg_index_t REG_SPARE_HI = 2'd3;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [31:0]                     s_tdata   = '0;   // weight
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [mbsd_pkg::OUT_DATA_W-1:0] m_tdata;          // block_sum, out_col, out_row
  logic                            m_tlast;          // final_cell
  logic                            m_tuser;          // size_error
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  cfg_index_t                      cfg_index = mbsd_pkg::REG_SOURCE;
  cfg_data_t                       cfg_data  = '0;

  int errors_seen;
  int sums_pending;
  int cycles     = 0;
  int cells_sent = 0;
  int ready_hold = 0;
  int stall_draw;
  bit no_gaps    = 1'b0;

  matrix_block_sum_downsampler_unit u_dut (.*);

  matrix_block_sum_downsampler_unit_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("matrix_block_sum_downsampler_unit_tb: errors");
      $finish;
    end
  end

  // Result side: after an accepted item, drop ready for a random stall or none.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_hold <= 0;
    end else if (!m_tready) begin
      if (ready_hold <= 1) m_tready <= 1'b1;
      if (ready_hold > 0) ready_hold <= ready_hold - 1;
    end else if (m_tvalid) begin
      stall_draw = no_gaps ? 0 : $urandom_range(0, 14);
      if (stall_draw > 0) begin
        m_tready   <= 1'b0;
        ready_hold <= stall_draw;
      end
    end
  end

  function automatic logic [31:0] draw_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_target(input int src);
    int divs[$];
    for (int d = 1; d <= src; d++)
      if (src % d == 0) divs.push_back(d);
    return divs[$urandom_range(0, divs.size() - 1)];
  endfunction

  task automatic push_cell(input logic [31:0] w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    cells_sent++;
  endtask

  // Hold the input until every expected sum is out, then let the pipeline empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sizes(input int src, input int tgt);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= mbsd_pkg::REG_SOURCE;
    cfg_data  <= cfg_data_t'(src);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= mbsd_pkg::REG_TARGET;
    cfg_data  <= cfg_data_t'(tgt);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_spare(input cfg_index_t index, input cfg_data_t value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int src;
    int tgt;
    int run;
    int pick;
    int directed;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: a partial first block, no sums yet
    push_cell('1);
    push_cell('0);
    push_cell(32'h8000_0000);
    push_cell(32'h0000_0001);
    // one 2x2 block of full-scale weights
    write_sizes(2, 1);
    repeat (4) push_cell('1);
    // scale one: every cell is its own sum
    write_sizes(2, 2);
    push_cell('0);
    push_cell(32'h0000_0001);
    push_cell(32'h8000_0000);
    push_cell('1);
    // unusable sizes: zero target, non-multiple, zero source, too large
    write_sizes(2, 0);
    push_cell(draw_weight());
    write_sizes(3, 2);
    push_cell(draw_weight());
    write_sizes(0, 1);
    push_cell(draw_weight());
    write_sizes(65, 1);
    push_cell(draw_weight());
    write_sizes(127, 127);
    push_cell(draw_weight());
    // unknown register index must not restart the matrix
    write_sizes(64, 64);
    push_cell(draw_weight());
    push_cell(draw_weight());
    write_spare(REG_SPARE_HI, cfg_data_t'($urandom));
    push_cell(draw_weight());
    push_cell(draw_weight());
    // one-cell matrix: every item is the final cell
    write_sizes(1, 1);
    push_cell('1);
    push_cell(draw_weight());
    directed = cells_sent;

    while (cells_sent < directed + CELL_COUNT) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        src = $urandom_range(1, 10);
        tgt = pick_target(src);
        write_sizes(src, tgt);
        run = src * src * $urandom_range(1, 2);
        // cut some matrices short so the next write lands mid-matrix
        if ($urandom_range(0, 3) == 0) run = $urandom_range(1, run);
        for (int k = 0; k < run; k++) begin
          if (k == run / 2 && $urandom_range(0, 4) == 0)
            write_spare($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                        cfg_data_t'($urandom));
          push_cell(draw_weight());
        end
      end else if (pick == 7) begin
        src = $urandom_range(0, 1) ? 64 : $urandom_range(33, 63);
        tgt = pick_target(src);
        write_sizes(src, tgt);
        run = $urandom_range(src, 3 * src);
        repeat (run) push_cell(draw_weight());
      end else begin
        do begin
          src = $urandom_range(0, 127);
          tgt = $urandom_range(0, 127);
        end while (src != 0 && tgt != 0 && src <= 64 && tgt <= 64 && src % tgt == 0);
        write_sizes(src, tgt);
        repeat ($urandom_range(1, 6)) push_cell(draw_weight());
      end
    end

    drain();
    if (errors_seen == 0 && sums_pending == 0)
      $display("matrix_block_sum_downsampler_unit_tb: clean");
    else
      $display("matrix_block_sum_downsampler_unit_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mbsd_pkg.sv
src/mbsd_cfg.sv
src/mbsd_pos.sv
src/mbsd_acc.sv
src/mbsd_outq.sv
src/matrix_block_sum_downsampler_unit.sv
src/mbsd_checker.sv
verif/matrix_block_sum_downsampler_unit_checker.sv
verif/matrix_block_sum_downsampler_unit_tb.sv
